// ===== design/mcbsa_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbsa_pkg
// shared widths, codes and control structs of the slot allocator
// ----------------------------------------------------------------------------
package mcbsa_pkg;

  // sizing
  localparam int NUM_CH     = 6;
  localparam int SLOTS      = 64;
  localparam int MAP_W      = (SLOTS < 64) ? SLOTS : 64;
  localparam int CHUNK      = (MAP_W < 8) ? MAP_W : 8;
  localparam int NUM_CHUNKS = (MAP_W + CHUNK - 1) / CHUNK;
  localparam int PAD_W      = NUM_CHUNKS * CHUNK;
  localparam int IDX_W      = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int K_W        = (CHUNK > 1) ? $clog2(CHUNK) : 1;
  localparam int RUN_W      = $clog2(CHUNK + 1);
  localparam int CH_AW      = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;

  // field widths
  localparam int OP_W     = 2;
  localparam int CH_W     = 3;
  localparam int RANK_W   = 6;
  localparam int STAT_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int CNT_W    = 7;
  localparam int EN_W     = 6;
  localparam int POS_W    = 7;
  localparam int ENTRY_W  = MAP_W + CNT_W;

  // configuration
  localparam int REG_W = 1;
  localparam logic [REG_W-1:0] REG_BUF_SIZE = 1'b0;
  localparam logic [REG_W-1:0] REG_CH_EN    = 1'b1;
  localparam logic [CNT_W-1:0] BUF_SIZE_RST = 7'd64;
  localparam logic [EN_W-1:0]  CH_EN_RST    = 6'd63;

  typedef enum logic [OP_W-1:0] {
    OP_STORE   = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_COUNT   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_DISABLED = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // scanner control
  typedef struct packed {
    logic             start;
    logic             find_zero;
    logic [RANK_W-1:0] rank;
    logic [CNT_W-1:0]  limit;
  } scan_req_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [POS_W-1:0] pos;
  } scan_res_t;

endpackage

// ===== design/mcbsa_ram.sv =====
// ----------------------------------------------------------------------------
// mcbsa_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module mcbsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mcbsa_scan.sv =====
// ----------------------------------------------------------------------------
// mcbsa_scan
// walks a channel bitmap one chunk a cycle: lowest free slot or rank select
// ----------------------------------------------------------------------------
module mcbsa_scan import mcbsa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_req_t        req,
  input  logic [MAP_W-1:0] map,
  output scan_res_t        res
);

  logic               busy_r, busy_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   seen_r, seen_nxt;
  logic               hit_r, hit_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               mode_r, mode_nxt;
  logic [RANK_W-1:0]  rank_r, rank_nxt;
  logic [CNT_W-1:0]   limit_r, limit_nxt;

  logic [PAD_W-1:0]   map_pad;
  logic [CHUNK-1:0]   chunk;
  logic [POS_W-1:0]   base;
  logic [CNT_W-1:0]   tgt;
  logic [RUN_W-1:0]   run;
  logic               z_hit, s_hit, hit_now, last;
  logic [K_W-1:0]     z_k, s_k, k_now;

  assign map_pad = PAD_W'(map);
  assign chunk   = map_pad[idx_r*CHUNK +: CHUNK];
  assign base    = POS_W'(idx_r) * POS_W'(CHUNK);
  assign tgt     = CNT_W'(rank_r) - seen_r;

  always_comb begin
    z_hit = 1'b0;
    z_k   = '0;
    // descending so the lowest free position wins
    for (int k = CHUNK - 1; k >= 0; k--) begin
      if (!chunk[k] && ((base + POS_W'(k)) < POS_W'(limit_r))) begin
        z_hit = 1'b1;
        z_k   = K_W'(k);
      end
    end
  end

  always_comb begin
    run   = '0;
    s_hit = 1'b0;
    s_k   = '0;
    for (int k = 0; k < CHUNK; k++) begin
      if (chunk[k]) begin
        if (!s_hit && (CNT_W'(run) == tgt)) begin
          s_hit = 1'b1;
          s_k   = K_W'(k);
        end
        run = run + RUN_W'(1);
      end
    end
  end

  assign hit_now = mode_r ? z_hit : s_hit;
  assign k_now   = mode_r ? z_k : s_k;
  assign last    = (idx_r == IDX_W'(NUM_CHUNKS - 1));

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    seen_nxt  = seen_r;
    hit_nxt   = hit_r;
    pos_nxt   = pos_r;
    mode_nxt  = mode_r;
    rank_nxt  = rank_r;
    limit_nxt = limit_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      seen_nxt  = '0;
      mode_nxt  = req.find_zero;
      rank_nxt  = req.rank;
      limit_nxt = req.limit;
    end else if (busy_r) begin
      if (hit_now || last) begin
        busy_nxt = 1'b0;
        hit_nxt  = hit_now;
        pos_nxt  = base + POS_W'(k_now);
      end else begin
        idx_nxt  = idx_r + IDX_W'(1);
        seen_nxt = seen_r + CNT_W'(run);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      seen_r <= '0;
      hit_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      seen_r <= seen_nxt;
      hit_r  <= hit_nxt;
    end
    pos_r   <= pos_nxt;
    mode_r  <= mode_nxt;
    rank_r  <= rank_nxt;
    limit_r <= limit_nxt;
  end

  assign res.done = busy_r && (hit_now || last);
  assign res.hit  = hit_r;
  assign res.pos  = pos_r;

endmodule

// ===== design/multi_channel_bitmap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// multi_channel_bitmap_slot_allocator
// per-channel occupancy bitmaps and fill counts held in one ram, read-modify-write
// ----------------------------------------------------------------------------
// sequence: a count query or a disabled-channel request goes from the ram read
//   straight to done; store, lookup and release pass through the scan state, where
//   the bitmap scanner walks up to 8 8-bit chunks until it hits or runs out
// flow: a request word is taken only while idle, so one word is in flight at a time
// reset: synchronous active-low; all bitmaps free and counts zero at once through
//   per-entry valid bits, buffer_size 64, channel_enable 63
module multi_channel_bitmap_slot_allocator import mcbsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // request stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [2:0] channel, [8:3] rank, rest zero
  input  logic [1:0]        in_tuser,   // [1:0] opcode
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [5:0] slot, [12:6] ready_count, rest zero
  output logic [1:0]        out_tuser,  // [1:0] status
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [REG_W-1:0]  cfg_addr,
  input  logic [CNT_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [CNT_W-1:0] buf_size_r;
  logic [EN_W-1:0]  ch_en_r;

  // request held for the whole operation
  op_t              op_r;
  logic [CH_W-1:0]  ch_r;
  logic [RANK_W-1:0] rank_r;
  logic             en_r;

  // per-entry valid bits stand in for clearing the ram at reset
  logic [NUM_CH-1:0] vld_r, vld_nxt;

  // output register
  logic              out_vld_r, out_vld_nxt;
  status_t           out_stat_r, out_stat_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  // input word split
  op_t              in_op;
  logic [CH_W-1:0]  in_ch;
  logic [RANK_W-1:0] in_rank;
  logic [7:0]       en_ext;
  logic             in_ch_ok;
  logic             in_acc;

  // ram and entry view
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [CH_AW-1:0]   ch_idx;
  logic [MAP_W-1:0]   ent_map;
  logic [CNT_W-1:0]   ent_cnt;

  // scanner
  scan_req_t scan_req;
  scan_res_t scan_res;
  logic [CNT_W-1:0] usable;

  // result calculation
  logic             out_free;
  logic [MAP_W-1:0] slot_bit;
  logic [MAP_W-1:0] new_map;
  logic [CNT_W-1:0] new_cnt;

  assign in_op    = op_t'(in_tuser);
  assign in_ch    = in_tdata[2:0];
  assign in_rank  = in_tdata[8:3];
  assign en_ext   = 8'(ch_en_r);
  assign in_ch_ok = ({1'b0, in_ch} < 4'(NUM_CH)) && en_ext[in_ch];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // configuration writes, taken whenever offered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= BUF_SIZE_RST;
      ch_en_r    <= CH_EN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_BUF_SIZE: buf_size_r <= cfg_data;
        REG_CH_EN:    ch_en_r    <= cfg_data[EN_W-1:0];
        default:      ;
      endcase
    end
  end

  // capture the request on acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      ch_r   <= in_ch;
      rank_r <= in_rank;
      en_r   <= in_ch_ok;
    end
  end

  // state ram: {fill count, bitmap} per channel
  assign ch_idx = ch_r[CH_AW-1:0];

  mcbsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_CH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_idx),
    .wdata (ram_wdata),
    .re    (in_acc && in_ch_ok),
    .raddr (in_ch[CH_AW-1:0]),
    .rdata (ram_rdata)
  );

  // an entry never written reads as free and empty
  assign ent_map = vld_r[ch_idx] ? ram_rdata[MAP_W-1:0] : '0;
  assign ent_cnt = vld_r[ch_idx] ? ram_rdata[ENTRY_W-1:MAP_W] : '0;

  // usable slots, capped at the bitmap width
  assign usable = (buf_size_r > CNT_W'(MAP_W)) ? CNT_W'(MAP_W) : buf_size_r;

  // a store on a full count scans with no slots in range, so it misses
  always_comb begin
    scan_req.start     = (state_r == S_RD) && en_r && (op_r != OP_COUNT);
    scan_req.find_zero = (op_r == OP_STORE);
    scan_req.rank      = rank_r;
    scan_req.limit     = (ent_cnt < usable) ? usable : '0;
  end

  mcbsa_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scan_req),
    .map   (ent_map),
    .res   (scan_res)
  );

  assign out_free = !out_vld_r || out_tready;
  assign slot_bit = MAP_W'(1) << scan_res.pos;

  // result and write-back, worked out while the sequencer sits in done
  always_comb begin
    out_stat_nxt = ST_OK;
    out_slot_nxt = '0;
    out_cnt_nxt  = ent_cnt;
    new_map      = ent_map;
    new_cnt      = ent_cnt;
    ram_we       = 1'b0;
    if (!en_r) begin
      out_stat_nxt = ST_DISABLED;
      out_cnt_nxt  = '0;
    end else begin
      case (op_r)
        OP_STORE: begin
          if (scan_res.hit) begin
            new_map      = ent_map | slot_bit;
            new_cnt      = ent_cnt + CNT_W'(1);
            out_slot_nxt = SLOT_W'(scan_res.pos);
            out_cnt_nxt  = new_cnt;
            ram_we       = 1'b1;
          end else begin
            out_stat_nxt = ST_FULL;
          end
        end
        OP_LOOKUP: begin
          if (scan_res.hit) begin
            out_slot_nxt = SLOT_W'(scan_res.pos);
          end else begin
            out_stat_nxt = ST_NOTFOUND;
          end
        end
        OP_RELEASE: begin
          if (scan_res.hit) begin
            new_map      = ent_map & ~slot_bit;
            // count holds at zero when the bitmap and count disagree
            new_cnt      = (ent_cnt != '0) ? ent_cnt - CNT_W'(1) : '0;
            out_slot_nxt = SLOT_W'(scan_res.pos);
            out_cnt_nxt  = new_cnt;
            ram_we       = 1'b1;
          end else begin
            out_stat_nxt = ST_NOTFOUND;
          end
        end
        default: ;  // count query: fill count only
      endcase
    end
    // write only as the result is loaded
    ram_we = ram_we && (state_r == S_DONE) && out_free;
  end

  assign ram_wdata = {new_cnt, new_map};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RD;
      S_RD: begin
        if (scan_req.start) state_nxt = S_SCAN;
        else                state_nxt = S_DONE;
      end
      S_SCAN: if (scan_res.done) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (ram_we) begin
      vld_nxt[ch_idx] = 1'b1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_tvalid && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_stat_r <= out_stat_nxt;
      out_slot_r <= out_slot_nxt;
      out_cnt_r  <= out_cnt_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_slot_r};

  // ram is written back only while the result word is being loaded
  a_wb_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_DONE) && out_free)
    else $error("ram write outside result load");

  // the scanner only finishes while the sequencer waits on it
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> (state_r == S_SCAN))
    else $error("scan finished outside scan state");

  // a fresh result word always follows a done cycle
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_DONE))
    else $error("result word appeared without completion");

  // fill count written back never exceeds the bitmap width
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (new_cnt <= CNT_W'(MAP_W)))
    else $error("fill count out of range");

endmodule

// ===== bench/mcbsa_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcbsa_checker
// watches the request, result and register channels of the slot allocator,
// keeps its own copy of every channel bitmap and fill count, and compares
// each result word against the oldest predicted one
// ----------------------------------------------------------------------------
module mcbsa_checker import mcbsa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [15:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [15:0]         out_tdata,
  input  logic [1:0]          out_tuser,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [REG_W-1:0]    cfg_addr,
  input  logic [CNT_W-1:0]    cfg_data,
  output int                  mismatches,
  output int                  outstanding,
  output int                  results_checked,
  output int                  full_seen,
  output int                  disabled_seen,
  output int                  notfound_seen
);

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } alloc_result_t;

  bit [MAP_W-1:0] occ_map [NUM_CH];
  bit [CNT_W-1:0] fill [NUM_CH];
  bit [CNT_W-1:0] buf_size;
  bit [EN_W-1:0]  ch_enable;

  alloc_result_t pending_allocs [$];
  int mismatch_n, result_n, full_n, disabled_n, notfound_n;

  task automatic flag_mismatch(input string what, input int want_v, input int got_v);
    mismatch_n++;
    if (mismatch_n <= 10)
      $display("mismatch %0d, %s at result %0d: expected %0d, got %0d",
               mismatch_n, what, result_n, want_v, got_v);
  endtask

  task automatic predict_allocation(input op_t op, input logic [CH_W-1:0] ch,
                                    input logic [RANK_W-1:0] rank,
                                    output alloc_result_t res);
    int usable, hit, seen, j;
    bit enabled;
    bit [MAP_W-1:0] map;
    bit [CNT_W-1:0] cnt;
    res.status = ST_OK;
    res.slot = '0;
    res.count = '0;
    hit = -1;
    seen = 0;
    enabled = 1'b0;
    if (ch < NUM_CH)
      enabled = ch_enable[ch];
    if (!enabled) begin
      res.status = ST_DISABLED;
    end else begin
      map = occ_map[ch];
      cnt = fill[ch];
      case (op)
        OP_STORE: begin
          usable = (buf_size > MAP_W) ? MAP_W : buf_size;
          if (cnt < usable)
            for (j = 0; j < usable && hit < 0; j++)
              if (!map[j]) hit = j;
          if (hit < 0) begin
            res.status = ST_FULL;
          end else begin
            map[hit] = 1'b1;
            cnt++;
            res.slot = hit[SLOT_W-1:0];
          end
        end
        OP_LOOKUP, OP_RELEASE: begin
          // rank search covers the whole bitmap, not just the slots in use
          for (j = 0; j < MAP_W && hit < 0; j++)
            if (map[j]) begin
              if (seen == rank) hit = j;
              seen++;
            end
          if (hit < 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.slot = hit[SLOT_W-1:0];
            if (op == OP_RELEASE) begin
              map[hit] = 1'b0;
              if (cnt > 0) cnt--;
            end
          end
        end
        default: ;
      endcase
      occ_map[ch] = map;
      fill[ch] = cnt;
      res.count = cnt;
    end
  endtask

  always @(posedge clk) begin : watch
    alloc_result_t want, got;
    if (!rst_n) begin
      foreach (occ_map[c]) begin
        occ_map[c] = '0;
        fill[c] = '0;
      end
      buf_size = BUF_SIZE_RST;
      ch_enable = CH_EN_RST;
      pending_allocs.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.slot = out_tdata[5:0];
        got.count = out_tdata[12:6];
        result_n++;
        case (got.status)
          ST_FULL:     full_n++;
          ST_DISABLED: disabled_n++;
          ST_NOTFOUND: notfound_n++;
          default: ;
        endcase
        if (pending_allocs.size() == 0) begin
          flag_mismatch("result word with nothing pending, status", -1, got.status);
        end else begin
          want = pending_allocs.pop_front();
          if (got.status !== want.status) flag_mismatch("status", want.status, got.status);
          if (got.slot !== want.slot) flag_mismatch("slot", want.slot, got.slot);
          if (got.count !== want.count) flag_mismatch("ready_count", want.count, got.count);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == REG_BUF_SIZE)
          buf_size = cfg_data;
        else if (cfg_addr == REG_CH_EN)
          ch_enable = cfg_data[EN_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        predict_allocation(op_t'(in_tuser), in_tdata[2:0], in_tdata[8:3], want);
        pending_allocs.push_back(want);
      end
    end
    mismatches <= mismatch_n;
    outstanding <= pending_allocs.size();
    results_checked <= result_n;
    full_seen <= full_n;
    disabled_seen <= disabled_n;
    notfound_seen <= notfound_n;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// request stimulus for the multi-channel slot allocator: a directed opening,
// then random store bursts, rank lookups and releases under several register
// settings, with random stalls on both streams; checking sits in mcbsa_checker
// ----------------------------------------------------------------------------
module tb;
  import mcbsa_pkg::*;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int DRAIN_CYCLES    = 16;   // beyond the longest scan latency
  localparam int PHASE_WORDS     = 80;
  localparam int NUM_PHASES      = 6;
  localparam int HOLD_OFF_CYCLES = 400;

  logic clk;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;    // [2:0] channel, [8:3] rank
  logic [1:0]        in_tuser = '0;    // [1:0] opcode
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;        // [5:0] slot, [12:6] ready_count
  logic [1:0]        out_tuser;        // [1:0] status
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [REG_W-1:0]  cfg_addr = '0;
  logic [CNT_W-1:0]  cfg_data = '0;

  int mismatches, outstanding, results_checked;
  int full_seen, disabled_seen, notfound_seen;
  int cycle_count = 0;
  int words_sent = 0;
  int settings_used = 0;
  logic hold_off_armed = 1'b0;
  bit   hold_off_done = 1'b0;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  multi_channel_bitmap_slot_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  mcbsa_checker alloc_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .full_seen       (full_seen),
    .disabled_seen   (disabled_seen),
    .notfound_seen   (notfound_seen)
  );

  // watchdog, well above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("no progress within %0d cycles", CYCLE_LIMIT);
      $display("tb failed");
      $finish;
    end
  end

  // result side back-pressure: open stretches, short random stalls, the odd
  // long stall, and once a very long hold-off so the allocator backs up
  initial begin : result_ready
    int kind, span;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_armed && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 30)      span = $urandom_range(20, 80);
        else if (kind < 85) span = $urandom_range(1, 20);
        else                span = $urandom_range(15, 40);
        repeat (span) begin
          if (kind < 30)      out_tready <= 1'b1;
          else if (kind < 85) out_tready <= ($urandom_range(0, 3) != 0);
          else                out_tready <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // offer one request word, hold it until taken, then maybe leave a gap;
  // a quiet run never idles between words
  task automatic request(input op_t op, input logic [CH_W-1:0] ch,
                         input logic [RANK_W-1:0] rank, input bit quiet);
    int pick, gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'd0, rank, ch};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    gap = 0;
    if (!quiet) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90)      gap = $urandom_range(10, 30);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering, let every pending word come back, then wait out the drain
  // time before going on
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers back to back on the cfg channel, only while idle
  task automatic write_settings(input logic [CNT_W-1:0] bs, input logic [EN_W-1:0] en);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_addr <= REG_BUF_SIZE;
    cfg_data <= bs;
    do @(posedge clk); while (!cfg_ready);
    cfg_addr <= REG_CH_EN;
    cfg_data <= {1'b0, en};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // random traffic shaped like real use: store bursts that fill a channel,
  // short runs of lookups and releases at low ranks, count queries, and
  // some fully random words including out-of-range channels
  task automatic random_phase(input int quota);
    int sent, kind, len, rk;
    bit quiet;
    logic [CH_W-1:0] ch;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(0, 99);
      quiet = ($urandom_range(0, 3) == 0);
      ch = CH_W'($urandom_range(0, NUM_CH - 1));
      if (kind < 40) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
        repeat (len) request(OP_STORE, ch, RANK_W'($urandom_range(0, 63)), quiet);
        sent += len;
      end else if (kind < 75) begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          rk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
          request($urandom_range(0, 1) ? OP_RELEASE : OP_LOOKUP, ch, RANK_W'(rk), quiet);
        end
        sent += len;
      end else if (kind < 85) begin
        request(OP_COUNT, ch, RANK_W'($urandom_range(0, 63)), quiet);
        sent++;
      end else begin
        request(op_t'($urandom_range(0, 3)), CH_W'($urandom_range(0, 7)),
                RANK_W'($urandom_range(0, 63)), quiet);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int p;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening under the reset settings (64 slots, all channels on)
    request(OP_COUNT,   3'd0, 6'd0,  1'b0);  // empty channel
    request(OP_LOOKUP,  3'd0, 6'd0,  1'b0);  // nothing filled yet
    request(OP_RELEASE, 3'd0, 6'd0,  1'b0);
    request(OP_STORE,   3'd0, 6'd0,  1'b1);  // slots 0, 1, 2
    request(OP_STORE,   3'd0, 6'd63, 1'b1);
    request(OP_STORE,   3'd0, 6'd0,  1'b0);
    request(OP_LOOKUP,  3'd0, 6'd1,  1'b0);
    request(OP_RELEASE, 3'd0, 6'd0,  1'b0);  // frees slot 0
    request(OP_STORE,   3'd0, 6'd0,  1'b0);  // lowest free is slot 0 again
    request(OP_LOOKUP,  3'd0, 6'd63, 1'b0);  // rank beyond the filled slots
    request(OP_RELEASE, 3'd0, 6'd63, 1'b0);
    request(OP_STORE,   3'd6, 6'd0,  1'b0);  // channels past the last one
    request(OP_LOOKUP,  3'd7, 6'd5,  1'b0);
    request(OP_COUNT,   3'd5, 6'd0,  1'b0);

    // one usable slot, only channel 0 on
    write_settings(7'd1, 6'b000001);
    request(OP_STORE,   3'd0, 6'd0,  1'b0);  // count already past the size
    request(OP_STORE,   3'd1, 6'd0,  1'b0);  // enable bit clear
    request(OP_LOOKUP,  3'd0, 6'd2,  1'b0);  // rank search ignores the size
    request(OP_COUNT,   3'd0, 6'd0,  1'b0);

    // zero size: every store full
    write_settings(7'd0, 6'b100000);
    request(OP_STORE,   3'd5, 6'd0,  1'b0);
    request(OP_COUNT,   3'd5, 6'd0,  1'b0);
    request(OP_RELEASE, 3'd0, 6'd0,  1'b0);

    // size above the bitmap, capped at 64
    write_settings(7'd127, 6'd63);
    request(OP_STORE,   3'd5, 6'd0,  1'b0);
    request(OP_STORE,   3'd0, 6'd0,  1'b0);

    // random part, the long result hold-off lands early in it
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_settings(7'd64, 6'd63);
        1: write_settings(7'd1, EN_W'($urandom_range(1, 63)));
        2: write_settings(CNT_W'($urandom_range(2, 8)), EN_W'($urandom_range(1, 63)));
        3: write_settings(7'd127, 6'd1);
        4: write_settings(7'd0, 6'd63);
        default: write_settings(CNT_W'($urandom_range(1, 64)), 6'd63);
      endcase
      // armed once the block is idle, so requests keep coming during the hold-off
      if (p == 0) hold_off_armed <= 1'b1;
      random_phase(PHASE_WORDS);
    end

    wait_idle();
    $display("%0d request words under %0d register settings, %0d result words checked",
             words_sent, settings_used + 1, results_checked);
    $display("results: %0d full, %0d disabled, %0d rank misses; %0d never answered",
             full_seen, disabled_seen, notfound_seen, outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/mcbsa_pkg.sv
design/mcbsa_ram.sv
design/mcbsa_scan.sv
design/multi_channel_bitmap_slot_allocator.sv
bench/mcbsa_checker.sv
bench/tb.sv
